// File: design/best_fit_heap_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// Best-fit heap allocator assertion macros
// Shared property wrappers clocked on i_clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`define BEST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define BFHA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFHA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bfha_pkg.sv
// ----------------------------------------------------------------------------
// Best-fit heap allocator package
// Request and response types, status and operation codes, default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package bfha_pkg;

    localparam int HEAP_BYTES_DEF   = 65536;
    localparam int ALIGN_BYTES_DEF  = 8;
    localparam int HEADER_BYTES_DEF = 16;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_REALLOC = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    localparam logic [16:0] BYTES_MAX  = 17'h1FFFF;
    localparam logic [13:0] BLOCKS_MAX = 14'h3FFF;

    typedef struct packed {
        logic [1:0]  op;
        logic [16:0] req_size;
        logic [15:0] block_addr;
    } t_req;

    typedef struct packed {
        logic [15:0] result_addr;
        logic [1:0]  status;
        logic        moved;
        logic [16:0] bytes_in_use;
        logic [13:0] blocks_in_use;
    } t_rsp;

endpackage

`default_nettype wire

// File: design/best_fit_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// Best-fit heap allocator
// Address-indexed header store walked by a sequencer, with an output
// register on the response side.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  request   in         i_in_valid / o_in_ready    i_in_data  (t_req)
//  response  out        o_out_valid / i_out_ready  o_out_data (t_rsp)
//
//  Alloc: the walk reads each block in the chain in turn and stops early on an
//  exact fit. Free: the walk reads each block in turn up to the target.
//  A moving realloc costs a free walk, an alloc walk and a second free walk.
//  The chain walk issues one header read per cycle on the store's read port.
//  After reset the S_INIT state writes the initial free header before o_in_ready rises.
//  A stalled response holds in the output register while the next request runs.
// ----------------------------------------------------------------------------
`default_nettype none
`include "best_fit_heap_allocator_unit_macros.svh"

module best_fit_heap_allocator_unit #(
    parameter int HEAP_BYTES   = bfha_pkg::HEAP_BYTES_DEF,
    parameter int ALIGN_BYTES  = bfha_pkg::ALIGN_BYTES_DEF,
    parameter int HEADER_BYTES = bfha_pkg::HEADER_BYTES_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire bfha_pkg::t_req  i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output bfha_pkg::t_rsp       o_out_data
);

    localparam int AW = $clog2(HEAP_BYTES / ALIGN_BYTES);
    localparam int DW = $clog2(HEAP_BYTES) + 1;

    logic           w_wr_en;
    logic [AW-1:0]  w_wr_addr;
    logic [DW-1:0]  w_wr_data;
    logic [AW-1:0]  w_rd_addr;
    logic [DW-1:0]  w_rd_data;
    logic           w_res_valid;
    logic           w_res_take;
    bfha_pkg::t_rsp w_res;
    logic           w_in_xfer;

    logic           r_out_valid;
    bfha_pkg::t_rsp r_out;

    bfha_hdr_ram #(
        .ADDR_BITS (AW),
        .DATA_BITS (DW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    bfha_engine #(
        .HEAP_BYTES   (HEAP_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_res_take),
        .o_res       (w_res),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data)
    );

    assign w_res_take = w_res_valid && (!r_out_valid || i_out_ready);
    assign w_in_xfer  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `BFHA_ASSERT_NXT(a_busy_after_xfer, w_in_xfer, !o_in_ready, "ready held after request transfer")
    `BFHA_ASSERT_IMP(a_moved_ok, o_out_valid && o_out_data.moved, o_out_data.status == bfha_pkg::ST_OK, "moved with failing status")
    `BFHA_ASSERT_IMP(a_fail_no_addr, o_out_valid && (o_out_data.status != bfha_pkg::ST_OK), o_out_data.result_addr == 16'd0, "address granted on failure")
    `BFHA_ASSERT_NXT(a_take_loads, w_res_take, o_out_valid, "response lost on handover")

endmodule

`default_nettype wire

// File: design/bfha_hdr_ram.sv
// ----------------------------------------------------------------------------
// Header store
// Single write, single read synchronous RAM, registered read, write-first.
// ----------------------------------------------------------------------------
`default_nettype none

module bfha_hdr_ram #(
    parameter int ADDR_BITS = 13,
    parameter int DATA_BITS = 17
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr_en,
    input  wire logic [ADDR_BITS-1:0] i_wr_addr,
    input  wire logic [DATA_BITS-1:0] i_wr_data,
    input  wire logic [ADDR_BITS-1:0] i_rd_addr,
    output logic      [DATA_BITS-1:0] o_rd_data
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            o_rd_data <= i_wr_data;
        end else begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/bfha_engine.sv
// ----------------------------------------------------------------------------
// Allocator sequencer
// Walks the block chain in the header store, commits splits and merges,
// keeps the byte and block totals.
// ----------------------------------------------------------------------------
`default_nettype none

module bfha_engine #(
    parameter int HEAP_BYTES   = bfha_pkg::HEAP_BYTES_DEF,
    parameter int ALIGN_BYTES  = bfha_pkg::ALIGN_BYTES_DEF,
    parameter int HEADER_BYTES = bfha_pkg::HEADER_BYTES_DEF,
    localparam int AW = $clog2(HEAP_BYTES / ALIGN_BYTES),
    localparam int SW = $clog2(HEAP_BYTES),
    localparam int DW = SW + 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire bfha_pkg::t_req  i_in_data,
    output logic                 o_in_ready,
    output logic                 o_res_valid,
    input  wire logic            i_res_take,
    output bfha_pkg::t_rsp       o_res,
    output logic                 o_wr_en,
    output logic [AW-1:0]        o_wr_addr,
    output logic [DW-1:0]        o_wr_data,
    output logic [AW-1:0]        o_rd_addr,
    input  wire logic [DW-1:0]   i_rd_data
);

    localparam int CW  = ((SW > 18) ? SW : 18) + 1;
    localparam int ALB = $clog2(ALIGN_BYTES);

    localparam logic [CW-1:0] C_HEAP = CW'(HEAP_BYTES);
    localparam logic [CW-1:0] C_HDR  = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] C_MT   = CW'(HEADER_BYTES + ALIGN_BYTES);
    localparam logic [CW-1:0] C_AM1  = CW'(ALIGN_BYTES - 1);
    localparam logic [CW-1:0] C_INIT = CW'(HEAP_BYTES - HEADER_BYTES);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_AWALK   = 4'd2;
    localparam logic [3:0] S_ACOMMIT = 4'd3;
    localparam logic [3:0] S_FWALK   = 4'd4;
    localparam logic [3:0] S_FNEXT   = 4'd5;
    localparam logic [3:0] S_DECIDE  = 4'd6;
    localparam logic [3:0] S_TAIL    = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]    r_state, n_state;
    logic          r_rel, n_rel;
    logic          r_move, n_move;
    logic [CW-1:0] r_size, n_size;
    logic [15:0]   r_pv, n_pv;
    logic [AW-1:0] r_tgt, n_tgt;
    logic [AW-1:0] r_cur, n_cur;
    logic          r_found, n_found;
    logic [AW-1:0] r_best, n_best;
    logic [SW-1:0] r_best_size, n_best_size;
    logic [CW-1:0] r_best_rem, n_best_rem;
    logic          r_prv_v, n_prv_v;
    logic          r_prv_free, n_prv_free;
    logic [AW-1:0] r_prv, n_prv;
    logic [SW-1:0] r_prv_size, n_prv_size;
    logic [SW-1:0] r_csize, n_csize;
    logic          r_nxt_v, n_nxt_v;
    logic          r_nxt_free, n_nxt_free;
    logic [SW-1:0] r_nxt_size, n_nxt_size;
    logic [15:0]   r_alloc_addr, n_alloc_addr;
    logic [AW-1:0] r_t_addr, n_t_addr;
    logic [DW-1:0] r_t_data, n_t_data;
    logic          r_tail_alloc, n_tail_alloc;
    logic [15:0]   r_addr, n_addr;
    logic [1:0]    r_status, n_status;
    logic          r_moved, n_moved;
    logic [16:0]   r_bytes, n_bytes;
    logic [13:0]   r_blocks, n_blocks;

    logic          c_add, c_sub, c_inc, c_dec;
    logic [CW-1:0] c_val;

    logic          w_free, w_last, w_fit, w_better;
    logic [SW-1:0] w_sz;
    logic [CW-1:0] w_cur_b, w_end_b, w_rem, w_best_b, w_btail_b, w_ctail_b;
    logic [AW-1:0] w_nxt;
    logic [CW-1:0] w_rs, w_pv, w_off;
    logic          w_pv_bad;
    logic          w_split, w_nf, w_pf;
    logic [CW-1:0] w_final, w_s1, w_s2, w_old, w_diff, w_merged, w_rest, w_t1, w_t2;
    logic [CW-1:0] w_sum;

    assign w_free    = i_rd_data[SW];
    assign w_sz      = i_rd_data[SW-1:0];
    assign w_cur_b   = CW'({r_cur, {ALB{1'b0}}});
    assign w_end_b   = w_cur_b + C_HDR + CW'(w_sz);
    assign w_last    = (w_end_b >= C_HEAP);
    assign w_nxt     = AW'(w_end_b >> ALB);
    assign w_fit     = w_free && (CW'(w_sz) >= r_size);
    assign w_rem     = CW'(w_sz) - r_size;
    assign w_better  = w_fit && (!r_found || (w_rem < r_best_rem));
    assign w_best_b  = CW'({r_best, {ALB{1'b0}}});
    assign w_btail_b = w_best_b + C_HDR + r_size;
    assign w_ctail_b = w_cur_b + C_HDR + r_size;

    assign w_rs     = (CW'(i_in_data.req_size) + C_AM1) & ~C_AM1;
    assign w_pv     = CW'(i_in_data.block_addr);
    assign w_off    = w_pv - C_HDR;
    assign w_pv_bad = (w_pv < C_HDR) || (w_pv >= C_HEAP) || (w_off[ALB-1:0] != '0);

    assign w_split  = (r_best_rem >= C_MT);
    assign w_final  = w_split ? r_size : CW'(r_best_size);
    assign w_nf     = r_nxt_v && r_nxt_free;
    assign w_pf     = r_prv_v && r_prv_free;
    assign w_s1     = CW'(r_csize) + (w_nf ? (C_HDR + CW'(r_nxt_size)) : '0);
    assign w_s2     = w_pf ? (CW'(r_prv_size) + C_HDR + w_s1) : w_s1;
    assign w_old    = CW'(r_csize);
    assign w_diff   = w_old - r_size;
    assign w_merged = w_old + C_HDR + CW'(r_nxt_size);
    assign w_rest   = w_merged - r_size;
    assign w_t1     = w_nf ? (w_diff + CW'(r_nxt_size)) : (w_diff - C_HDR);
    assign w_t2     = w_rest - C_HDR;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = '{result_addr: r_addr, status: r_status, moved: r_moved,
                           bytes_in_use: r_bytes, blocks_in_use: r_blocks};

    always_comb begin
        n_state      = r_state;
        n_rel        = r_rel;
        n_move       = r_move;
        n_size       = r_size;
        n_pv         = r_pv;
        n_tgt        = r_tgt;
        n_cur        = r_cur;
        n_found      = r_found;
        n_best       = r_best;
        n_best_size  = r_best_size;
        n_best_rem   = r_best_rem;
        n_prv_v      = r_prv_v;
        n_prv_free   = r_prv_free;
        n_prv        = r_prv;
        n_prv_size   = r_prv_size;
        n_csize      = r_csize;
        n_nxt_v      = r_nxt_v;
        n_nxt_free   = r_nxt_free;
        n_nxt_size   = r_nxt_size;
        n_alloc_addr = r_alloc_addr;
        n_t_addr     = r_t_addr;
        n_t_data     = r_t_data;
        n_tail_alloc = r_tail_alloc;
        n_addr       = r_addr;
        n_status     = r_status;
        n_moved      = r_moved;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_cur;
        o_wr_data    = '0;
        o_rd_addr    = '0;
        c_add        = 1'b0;
        c_sub        = 1'b0;
        c_inc        = 1'b0;
        c_dec        = 1'b0;
        c_val        = '0;

        case (r_state)
            S_INIT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = '0;
                o_wr_data = {1'b1, C_INIT[SW-1:0]};
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rel    = (i_in_data.op == bfha_pkg::OP_FREE) ||
                               (i_in_data.req_size == '0);
                    n_move   = 1'b0;
                    n_size   = w_rs;
                    n_pv     = i_in_data.block_addr;
                    n_tgt    = AW'(w_off >> ALB);
                    n_cur    = '0;
                    n_found  = 1'b0;
                    n_prv_v  = 1'b0;
                    n_addr   = '0;
                    n_moved  = 1'b0;
                    n_status = bfha_pkg::ST_OK;
                    case (i_in_data.op)
                        bfha_pkg::OP_ALLOC: begin
                            if (i_in_data.req_size == '0) begin
                                n_status = bfha_pkg::ST_BAD;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_AWALK;
                            end
                        end
                        bfha_pkg::OP_FREE: begin
                            if (i_in_data.block_addr == '0) begin
                                n_state = S_DONE;
                            end else if (w_pv_bad) begin
                                n_status = bfha_pkg::ST_BAD;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_FWALK;
                            end
                        end
                        bfha_pkg::OP_REALLOC: begin
                            if (i_in_data.block_addr == '0) begin
                                if (i_in_data.req_size == '0) begin
                                    n_status = bfha_pkg::ST_BAD;
                                    n_state  = S_DONE;
                                end else begin
                                    n_state = S_AWALK;
                                end
                            end else if (w_pv_bad) begin
                                n_status = bfha_pkg::ST_BAD;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_FWALK;
                            end
                        end
                        default: begin
                            n_status = bfha_pkg::ST_BAD;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_AWALK: begin
                if (w_better) begin
                    n_found     = 1'b1;
                    n_best      = r_cur;
                    n_best_size = w_sz;
                    n_best_rem  = w_rem;
                end
                if ((w_better && (w_rem == '0)) || w_last) begin
                    if (r_found || w_better) begin
                        n_state = S_ACOMMIT;
                    end else begin
                        n_status = bfha_pkg::ST_NOFIT;
                        n_addr   = '0;
                        n_moved  = 1'b0;
                        n_state  = S_DONE;
                    end
                end else begin
                    n_cur     = w_nxt;
                    o_rd_addr = w_nxt;
                end
            end
            S_ACOMMIT: begin
                o_wr_en      = 1'b1;
                o_wr_addr    = r_best;
                o_wr_data    = {1'b0, w_final[SW-1:0]};
                c_add        = 1'b1;
                c_val        = w_final;
                c_inc        = 1'b1;
                n_alloc_addr = 16'(w_best_b + C_HDR);
                n_t_addr     = AW'(w_btail_b >> ALB);
                n_t_data     = {1'b1, SW'(r_best_rem - C_HDR)};
                n_tail_alloc = 1'b1;
                if (w_split) begin
                    n_state = S_TAIL;
                end else if (r_move) begin
                    n_cur   = '0;
                    n_prv_v = 1'b0;
                    n_state = S_FWALK;
                end else begin
                    n_addr   = 16'(w_best_b + C_HDR);
                    n_status = bfha_pkg::ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_FWALK: begin
                if (r_cur == r_tgt) begin
                    if (w_free) begin
                        n_status = bfha_pkg::ST_BAD;
                        n_state  = S_DONE;
                    end else begin
                        n_csize = w_sz;
                        if (w_last) begin
                            n_nxt_v = 1'b0;
                            n_state = S_DECIDE;
                        end else begin
                            n_nxt_v   = 1'b1;
                            o_rd_addr = w_nxt;
                            n_state   = S_FNEXT;
                        end
                    end
                end else if ((r_cur > r_tgt) || w_last) begin
                    n_status = bfha_pkg::ST_BAD;
                    n_state  = S_DONE;
                end else begin
                    n_prv_v    = 1'b1;
                    n_prv      = r_cur;
                    n_prv_free = w_free;
                    n_prv_size = w_sz;
                    n_cur      = w_nxt;
                    o_rd_addr  = w_nxt;
                end
            end
            S_FNEXT: begin
                n_nxt_free = w_free;
                n_nxt_size = w_sz;
                n_state    = S_DECIDE;
            end
            S_DECIDE: begin
                n_tail_alloc = 1'b0;
                n_t_addr     = AW'(w_ctail_b >> ALB);
                if (r_move || r_rel) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = w_pf ? r_prv : r_cur;
                    o_wr_data = {1'b1, w_s2[SW-1:0]};
                    c_sub     = 1'b1;
                    c_val     = w_old;
                    c_dec     = 1'b1;
                    n_addr    = r_move ? r_alloc_addr : 16'd0;
                    n_moved   = r_move;
                    n_status  = bfha_pkg::ST_OK;
                    n_state   = S_DONE;
                end else if (r_size <= w_old) begin
                    n_addr   = r_pv;
                    n_status = bfha_pkg::ST_OK;
                    if (w_diff >= C_MT) begin
                        o_wr_en   = 1'b1;
                        o_wr_data = {1'b0, r_size[SW-1:0]};
                        n_t_data  = {1'b1, w_t1[SW-1:0]};
                        c_sub     = 1'b1;
                        c_val     = w_diff;
                        n_state   = S_TAIL;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (w_nf && (w_merged >= r_size)) begin
                    n_addr   = r_pv;
                    n_status = bfha_pkg::ST_OK;
                    o_wr_en  = 1'b1;
                    c_add    = 1'b1;
                    if (w_rest >= C_MT) begin
                        o_wr_data = {1'b0, r_size[SW-1:0]};
                        n_t_data  = {1'b1, w_t2[SW-1:0]};
                        c_val     = r_size - w_old;
                        n_state   = S_TAIL;
                    end else begin
                        o_wr_data = {1'b0, w_merged[SW-1:0]};
                        c_val     = w_merged - w_old;
                        n_state   = S_DONE;
                    end
                end else begin
                    n_move  = 1'b1;
                    n_found = 1'b0;
                    n_cur   = '0;
                    n_state = S_AWALK;
                end
            end
            S_TAIL: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_t_addr;
                o_wr_data = r_t_data;
                if (r_tail_alloc && r_move) begin
                    n_cur   = '0;
                    n_prv_v = 1'b0;
                    n_state = S_FWALK;
                end else begin
                    if (r_tail_alloc) begin
                        n_addr   = r_alloc_addr;
                        n_status = bfha_pkg::ST_OK;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        w_sum    = CW'(r_bytes) + c_val;
        n_bytes  = r_bytes;
        n_blocks = r_blocks;
        if (c_add) begin
            n_bytes = (w_sum > CW'(bfha_pkg::BYTES_MAX)) ? bfha_pkg::BYTES_MAX : w_sum[16:0];
        end else if (c_sub) begin
            n_bytes = (CW'(r_bytes) >= c_val) ? 17'(CW'(r_bytes) - c_val) : 17'd0;
        end
        if (c_inc && (r_blocks != bfha_pkg::BLOCKS_MAX)) begin
            n_blocks = r_blocks + 14'd1;
        end else if (c_dec && (r_blocks != '0)) begin
            n_blocks = r_blocks - 14'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_bytes  <= '0;
            r_blocks <= '0;
            r_move   <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bytes  <= n_bytes;
            r_blocks <= n_blocks;
            r_move   <= n_move;
            r_found  <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rel        <= n_rel;
        r_size       <= n_size;
        r_pv         <= n_pv;
        r_tgt        <= n_tgt;
        r_cur        <= n_cur;
        r_best       <= n_best;
        r_best_size  <= n_best_size;
        r_best_rem   <= n_best_rem;
        r_prv_v      <= n_prv_v;
        r_prv_free   <= n_prv_free;
        r_prv        <= n_prv;
        r_prv_size   <= n_prv_size;
        r_csize      <= n_csize;
        r_nxt_v      <= n_nxt_v;
        r_nxt_free   <= n_nxt_free;
        r_nxt_size   <= n_nxt_size;
        r_alloc_addr <= n_alloc_addr;
        r_t_addr     <= n_t_addr;
        r_t_data     <= n_t_data;
        r_tail_alloc <= n_tail_alloc;
        r_addr       <= n_addr;
        r_status     <= n_status;
        r_moved      <= n_moved;
    end

endmodule

`default_nettype wire
